FILE: rtl/oaht_pkg.sv
package oaht_pkg;

   localparam int CAPACITY   = 256;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int LOAD_LIMIT = 3 * CAPACITY / 4;
   localparam bit CAP_POW2   = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam int KEY_W      = 32;
   localparam int HASH_W     = 32;
   localparam int VALUE_W    = 64;

   localparam logic [HASH_W-1:0] MOD_RECIP = HASH_W'((64'd1 << HASH_W) / CAPACITY);

   typedef logic [1:0] op_type;
   localparam op_type OP_GET = 2'd0;
   localparam op_type OP_SET = 2'd1;
   localparam op_type OP_DEL = 2'd2;

   typedef logic [1:0] slot_state_type;
   localparam slot_state_type SLOT_EMPTY = 2'd0;
   localparam slot_state_type SLOT_TOMB  = 2'd1;
   localparam slot_state_type SLOT_OCC   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_FETCH,
      ST_PROBE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic quick;
      logic mod_step;
      logic fetch;
      logic probe;
   } ctrl_cmd_type;

   typedef struct packed {
      logic quick;
      logic mod_done;
      logic probe_end;
   } dp_status_type;

endpackage

FILE: rtl/open_addressing_hash_table.sv
// A request that needs no probe responds in the cycle after acceptance.
// A probed request first computes the reciprocal modulo (quotient, then reduction)
// when CAPACITY is not a power of two, then reads k slots (1..CAPACITY) through
// the slot RAM read port, one slot per cycle, and takes no new request meanwhile.
// Reset clears the controller, the slot valid bits and the used count at once, no sweep.
// The response strobe lasts one cycle; the receiver cannot stall.
module open_addressing_hash_table
   import oaht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [KEY_W-1:0]   req_key_id,
   input  logic [HASH_W-1:0]  req_key_hash,
   input  logic [VALUE_W-1:0] req_value_in,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [VALUE_W-1:0] rsp_value_out,
   output logic               rsp_status
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   oaht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   oaht_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_operation),
      .req_key_id    (req_key_id),
      .req_key_hash  (req_key_hash),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status)
   );

endmodule

FILE: rtl/oaht_ram.sv
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/oaht_ctrl.sv
module oaht_ctrl
   import oaht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !stat.quick) begin
               state_in = CAP_POW2 ? ST_FETCH : ST_MOD;
            end
         end
         ST_MOD: begin
            if (stat.mod_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (stat.probe_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.accept   = 1'b0;
      cmd.quick    = 1'b0;
      cmd.mod_step = 1'b0;
      cmd.fetch    = 1'b0;
      cmd.probe    = 1'b0;
      busy         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
            cmd.quick  = start && stat.quick;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/oaht_datapath.sv
module oaht_datapath
   import oaht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      stat,
   input  op_type             req_operation,
   input  logic [KEY_W-1:0]   req_key_id,
   input  logic [HASH_W-1:0]  req_key_hash,
   input  logic [VALUE_W-1:0] req_value_in,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [VALUE_W-1:0] rsp_value_out,
   output logic               rsp_status
);

   op_type               op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [HASH_W-1:0]    hash_ff;
   logic [HASH_W-1:0]    quot_ff;
   logic                 mod_phase_ff;
   logic [IDX_W-1:0]     cur_idx_ff;
   logic [IDX_W-1:0]     step_ff;
   logic [IDX_W-1:0]     tomb_ff;
   logic                 have_tomb_ff;
   logic [CNT_W-1:0]     used_ff;
   logic [CAPACITY-1:0]  valid_ff;
   logic                 valid_rd_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_status_ff;

   logic                 full;
   logic [2*HASH_W-1:0]  mod_prod;
   logic [IDX_W:0]       mod_sub;
   logic [IDX_W:0]       mod_red;
   logic [IDX_W-1:0]     next_idx;
   logic [IDX_W-1:0]     rd_addr;
   logic [KEY_W+1:0]     slot_rd;
   logic [VALUE_W-1:0]   value_rd;
   slot_state_type       cur_state;
   logic                 is_empty;
   logic                 is_tomb;
   logic                 is_match;
   logic                 have_now;
   logic [IDX_W-1:0]     tomb_now;
   logic                 end_exh;
   logic                 probe_done;
   logic                 found;
   logic [IDX_W-1:0]     slot_idx;
   slot_state_type       slot_found;
   logic                 slot_wr;
   slot_state_type       slot_wr_state;
   logic                 value_wr;

   assign full = used_ff >= CNT_W'(LOAD_LIMIT);

   assign stat.quick = (req_operation == OP_SET) ? full :
                       ((req_operation == OP_GET) || (req_operation == OP_DEL)) ?
                       (used_ff == '0) : 1'b1;

   assign mod_prod      = (2 * HASH_W)'(hash_ff) * (2 * HASH_W)'(MOD_RECIP);
   assign mod_sub       = hash_ff[IDX_W:0] - (quot_ff[IDX_W:0] * (IDX_W + 1)'(CAPACITY));
   assign mod_red       = (mod_sub >= (IDX_W + 1)'(CAPACITY)) ?
                          mod_sub - (IDX_W + 1)'(CAPACITY) : mod_sub;
   assign stat.mod_done = mod_phase_ff;

   assign next_idx = (cur_idx_ff == IDX_W'(CAPACITY - 1)) ? '0 : cur_idx_ff + IDX_W'(1);
   assign rd_addr  = cmd.probe ? next_idx : cur_idx_ff;

   assign cur_state = valid_rd_ff ? slot_rd[KEY_W+1:KEY_W] : SLOT_EMPTY;
   assign is_empty  = cur_state == SLOT_EMPTY;
   assign is_tomb   = cur_state == SLOT_TOMB;
   assign is_match  = (cur_state == SLOT_OCC) && (slot_rd[KEY_W-1:0] == key_ff);
   assign have_now  = have_tomb_ff || is_tomb;
   assign tomb_now  = have_tomb_ff ? tomb_ff : cur_idx_ff;
   assign end_exh   = !is_empty && !is_match && (step_ff == IDX_W'(CAPACITY - 1));

   assign stat.probe_end = is_empty || is_match || end_exh;
   assign probe_done     = cmd.probe && stat.probe_end;

   assign found      = is_match || is_empty || have_now;
   assign slot_idx   = (!is_match && have_now) ? tomb_now : cur_idx_ff;
   assign slot_found = is_match ? SLOT_OCC : (have_now ? SLOT_TOMB : SLOT_EMPTY);

   always_comb begin
      slot_wr       = 1'b0;
      slot_wr_state = SLOT_OCC;
      value_wr      = 1'b0;
      if (probe_done) begin
         case (op_ff)
            OP_SET: begin
               slot_wr  = found;
               value_wr = found;
            end
            OP_DEL: begin
               slot_wr       = is_match;
               slot_wr_state = SLOT_TOMB;
            end
            default: begin
               slot_wr = 1'b0;
            end
         endcase
      end
   end

   oaht_ram #(
      .WIDTH (KEY_W + 2),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr (slot_idx),
      .wr_data ({slot_wr_state, key_ff}),
      .rd_addr (rd_addr),
      .rd_data (slot_rd)
   );

   oaht_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_wr),
      .wr_addr (slot_idx),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (value_rd)
   );

   always_ff @(posedge clock) begin
      valid_rd_ff <= valid_ff[rd_addr];
      if (cmd.accept) begin
         op_ff        <= req_operation;
         key_ff       <= req_key_id;
         value_ff     <= req_value_in;
         hash_ff      <= req_key_hash;
         mod_phase_ff <= 1'b0;
         cur_idx_ff   <= CAP_POW2 ? req_key_hash[IDX_W-1:0] : '0;
         step_ff      <= '0;
         have_tomb_ff <= 1'b0;
      end else if (cmd.mod_step) begin
         mod_phase_ff <= 1'b1;
         if (mod_phase_ff) begin
            cur_idx_ff <= mod_red[IDX_W-1:0];
         end else begin
            quot_ff <= mod_prod[2*HASH_W-1:HASH_W];
         end
      end else if (cmd.probe && !stat.probe_end) begin
         cur_idx_ff <= next_idx;
         step_ff    <= step_ff + IDX_W'(1);
         if (is_tomb && !have_tomb_ff) begin
            tomb_ff      <= cur_idx_ff;
            have_tomb_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.quick || probe_done;
         if (slot_wr) begin
            valid_ff[slot_idx] <= 1'b1;
         end
         if (value_wr && (slot_found == SLOT_EMPTY)) begin
            used_ff <= used_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.quick) begin
         rsp_hit_ff    <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_status_ff <= (req_operation == OP_SET);
      end else if (probe_done) begin
         rsp_hit_ff    <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_status_ff <= 1'b0;
         case (op_ff)
            OP_GET: begin
               rsp_hit_ff   <= is_match;
               rsp_value_ff <= is_match ? value_rd : '0;
            end
            OP_SET: begin
               rsp_hit_ff    <= found && (slot_found != SLOT_OCC);
               rsp_status_ff <= !found;
            end
            OP_DEL: begin
               rsp_hit_ff <= is_match;
            end
            default: begin
               rsp_hit_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(LOAD_LIMIT))
      else $error("used count above load limit");

   a_probe_rsp: assert property (@(posedge clock) disable iff (reset)
      probe_done |=> rsp_valid_ff)
      else $error("probe ended without a response");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> !rsp_hit_ff && (rsp_value_ff == '0))
      else $error("rejected set carries hit or value");

   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_value_ff != '0) |-> rsp_hit_ff && (op_ff == OP_GET))
      else $error("value returned without a get hit");
`endif

endmodule
